### sv/assert_macros.svh
// Assertion macros used by the top level of the merge engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define UFM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checks that a condition never holds on a rising clock edge outside reset.
`define UFM_ASSERT_NEVER(lbl, cond, msg) \
  `UFM_ASSERT(lbl, !(cond), msg)

`endif

### sv/ufm_pkg.sv
// Shared constants, state type and helper function of the union-find merge engine.
package ufm_pkg;

  localparam int unsigned NODES_DEF = 1024;
  localparam int unsigned NODE_W    = 10;
  localparam int unsigned GAIN_W    = 19;
  localparam int unsigned MSIZE_W   = 11;
  localparam int unsigned IDX_MAX   = (1 << NODE_W) - 1;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_REDUCE,
    S_FIND_RD,
    S_FIND,
    S_COMP,
    S_SIZE_A,
    S_SIZE_B,
    S_MERGE,
    S_DONE
  } ufm_state_e;

  // Number of restoring subtract steps that bring a raw node index below nodes.
  function automatic int unsigned red_steps(int unsigned nodes);
    int unsigned k;
    k = 0;
    for (int unsigned i = 0; i < NODE_W; i++) begin
      if ((nodes << i) <= IDX_MAX) begin
        k = i + 1;
      end
    end
    return k;
  endfunction

endpackage

### sv/ufm_if.sv
// Valid/ready channel interfaces for node pairs in and merge results out.
interface ufm_in_if;
  logic                          valid;
  logic                          ready;
  logic [ufm_pkg::NODE_W-1:0]    node_a;
  logic [ufm_pkg::NODE_W-1:0]    node_b;

  modport source (output valid, node_a, node_b, input ready);
  modport sink   (input valid, node_a, node_b, output ready);
endinterface

interface ufm_out_if;
  logic                          valid;
  logic                          ready;
  logic                          already_joined;
  logic [ufm_pkg::GAIN_W-1:0]    pair_gain;
  logic [ufm_pkg::NODE_W-1:0]    new_root;
  logic [ufm_pkg::MSIZE_W-1:0]   merged_size;

  modport source (output valid, already_joined, pair_gain, new_root, merged_size, input ready);
  modport sink   (input valid, already_joined, pair_gain, new_root, merged_size, output ready);
endinterface

### sv/ufm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ufm_ram #(
  parameter int unsigned WIDTH = ufm_pkg::NODE_W,
  parameter int unsigned DEPTH = ufm_pkg::NODES_DEF,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### sv/union_find_merge_engine.sv
// Top level of the union-find merge engine: sequencer, parent and size tables.
//
//   channel    dir  payload                                            handshake
//   in_ch_i    in   node_a, node_b                                     valid/ready
//   out_ch_o   out  already_joined, pair_gain, new_root, merged_size   valid/ready
//
// After reset a clearing pass writes every table entry, with no input taken.
// A pair passes through the index reduction (R steps, where R is the reduction count,
// zero when NODES >= 1024), a parent-chain walk from each node, SIZE_A, SIZE_B, MERGE, DONE.
// Each hop is a read on the parent table's read port, repeated on the compression pass.
// The result waits in an output register; the next pair is accepted while it is not taken.
`include "assert_macros.svh"

module union_find_merge_engine #(
  parameter int unsigned NODES = ufm_pkg::NODES_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  ufm_in_if.sink         in_ch_i,
  ufm_out_if.source      out_ch_o
);

  localparam int unsigned IW        = $clog2(NODES);
  localparam int unsigned SW        = $clog2(NODES + 1);
  localparam int unsigned NW        = ufm_pkg::NODE_W;
  localparam int unsigned RED_STEPS = ufm_pkg::red_steps(NODES);
  localparam int unsigned RCW       = (RED_STEPS > 1) ? $clog2(RED_STEPS) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(NODES - 1);

  ufm_pkg::ufm_state_e state_q, state_d;

  logic [IW-1:0]  clr_q, clr_d;
  logic [NW-1:0]  idx_a_q, idx_a_d, idx_b_q, idx_b_d;
  logic [RCW-1:0] red_cnt_q, red_cnt_d;
  logic [IW-1:0]  cur_q, cur_d, start_q, start_d, top_q, top_d;
  logic [IW-1:0]  root_a_q, root_a_d, root_b_q, root_b_d;
  logic           side_q, side_d;
  logic [SW-1:0]  size_a_q, size_a_d;

  logic                         res_joined_q, res_joined_d;
  logic [ufm_pkg::GAIN_W-1:0]   res_gain_q, res_gain_d;
  logic [IW-1:0]                res_root_q, res_root_d;
  logic [SW-1:0]                res_size_q, res_size_d;

  logic                         out_valid_q, out_valid_d;
  logic                         out_joined_q, out_joined_d;
  logic [ufm_pkg::GAIN_W-1:0]   out_gain_q, out_gain_d;
  logic [NW-1:0]                out_root_q, out_root_d;
  logic [ufm_pkg::MSIZE_W-1:0]  out_size_q, out_size_d;

  logic          p_we, s_we;
  logic [IW-1:0] p_waddr, p_wdata, p_raddr, p_rdata;
  logic [IW-1:0] s_waddr, s_raddr;
  logic [SW-1:0] s_wdata, s_rdata;

  logic          in_take, out_take, out_load;
  logic [NW-1:0] red_sub, red_a_nxt, red_b_nxt;
  logic          root_hit;
  logic [IW-1:0] found_top;
  logic          joined, keep_b;
  logic [IW-1:0] keep_idx, give_idx;
  logic [SW-1:0] size_sum;
  logic [2*SW-1:0] size_prod;

  ufm_ram #(.WIDTH(IW), .DEPTH(NODES)) u_parent_ram (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (p_waddr),
    .wdata_i (p_wdata),
    .raddr_i (p_raddr),
    .rdata_o (p_rdata)
  );

  ufm_ram #(.WIDTH(SW), .DEPTH(NODES)) u_size_ram (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (s_waddr),
    .wdata_i (s_wdata),
    .raddr_i (s_raddr),
    .rdata_o (s_rdata)
  );

  assign in_ch_i.ready         = (state_q == ufm_pkg::S_IDLE);
  assign in_take               = in_ch_i.valid && in_ch_i.ready;
  assign out_take              = out_valid_q && out_ch_o.ready;
  assign out_load              = (state_q == ufm_pkg::S_DONE) && (!out_valid_q || out_ch_o.ready);

  assign out_ch_o.valid          = out_valid_q;
  assign out_ch_o.already_joined = out_joined_q;
  assign out_ch_o.pair_gain      = out_gain_q;
  assign out_ch_o.new_root       = out_root_q;
  assign out_ch_o.merged_size    = out_size_q;

  // One restoring step of the index reduction, on both nodes at once.
  assign red_sub   = NW'(NODES << red_cnt_q);
  assign red_a_nxt = (idx_a_q >= red_sub) ? idx_a_q - red_sub : idx_a_q;
  assign red_b_nxt = (idx_b_q >= red_sub) ? idx_b_q - red_sub : idx_b_q;

  // A side is finished when the root is found at the start node itself, or when the
  // compression pass reaches the node whose parent is the root.
  assign root_hit  = ((state_q == ufm_pkg::S_FIND) && (p_rdata == cur_q) && (start_q == cur_q))
                  || ((state_q == ufm_pkg::S_COMP) && (p_rdata == top_q));
  assign found_top = (state_q == ufm_pkg::S_FIND) ? cur_q : top_q;

  assign joined    = (root_a_q == root_b_q);
  assign keep_b    = (size_a_q < s_rdata);
  assign keep_idx  = keep_b ? root_b_q : root_a_q;
  assign give_idx  = keep_b ? root_a_q : root_b_q;
  assign size_sum  = size_a_q + s_rdata;
  assign size_prod = size_a_q * s_rdata;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ufm_pkg::S_CLEAR: begin
        if (clr_q == LAST_IDX) begin
          state_d = ufm_pkg::S_IDLE;
        end
      end
      ufm_pkg::S_IDLE: begin
        if (in_take) begin
          state_d = (RED_STEPS > 0) ? ufm_pkg::S_REDUCE : ufm_pkg::S_FIND_RD;
        end
      end
      ufm_pkg::S_REDUCE: begin
        if (red_cnt_q == '0) begin
          state_d = ufm_pkg::S_FIND_RD;
        end
      end
      ufm_pkg::S_FIND_RD: state_d = ufm_pkg::S_FIND;
      ufm_pkg::S_FIND: begin
        if (root_hit) begin
          state_d = side_q ? ufm_pkg::S_SIZE_A : ufm_pkg::S_FIND_RD;
        end else if (p_rdata == cur_q) begin
          state_d = ufm_pkg::S_COMP;
        end
      end
      ufm_pkg::S_COMP: begin
        if (root_hit) begin
          state_d = side_q ? ufm_pkg::S_SIZE_A : ufm_pkg::S_FIND_RD;
        end
      end
      ufm_pkg::S_SIZE_A: state_d = ufm_pkg::S_SIZE_B;
      ufm_pkg::S_SIZE_B: state_d = ufm_pkg::S_MERGE;
      ufm_pkg::S_MERGE:  state_d = ufm_pkg::S_DONE;
      ufm_pkg::S_DONE: begin
        if (out_load) begin
          state_d = ufm_pkg::S_IDLE;
        end
      end
      default: state_d = ufm_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    clr_d        = clr_q;
    idx_a_d      = idx_a_q;
    idx_b_d      = idx_b_q;
    red_cnt_d    = red_cnt_q;
    cur_d        = cur_q;
    start_d      = start_q;
    top_d        = top_q;
    root_a_d     = root_a_q;
    root_b_d     = root_b_q;
    side_d       = side_q;
    size_a_d     = size_a_q;
    res_joined_d = res_joined_q;
    res_gain_d   = res_gain_q;
    res_root_d   = res_root_q;
    res_size_d   = res_size_q;
    p_we         = 1'b0;
    p_waddr      = cur_q;
    p_wdata      = top_q;
    p_raddr      = cur_q;
    s_we         = 1'b0;
    s_waddr      = keep_idx;
    s_wdata      = size_sum;
    s_raddr      = root_a_q;

    unique case (state_q)
      ufm_pkg::S_CLEAR: begin
        p_we    = 1'b1;
        p_waddr = clr_q;
        p_wdata = clr_q;
        s_we    = 1'b1;
        s_waddr = clr_q;
        s_wdata = SW'(1);
        clr_d   = clr_q + 1'b1;
      end
      ufm_pkg::S_IDLE: begin
        if (in_take) begin
          idx_a_d   = in_ch_i.node_a;
          idx_b_d   = in_ch_i.node_b;
          red_cnt_d = RCW'(RED_STEPS - 1);
          cur_d     = IW'(in_ch_i.node_a);
          start_d   = IW'(in_ch_i.node_a);
          side_d    = 1'b0;
        end
      end
      ufm_pkg::S_REDUCE: begin
        idx_a_d   = red_a_nxt;
        idx_b_d   = red_b_nxt;
        red_cnt_d = red_cnt_q - 1'b1;
        if (red_cnt_q == '0) begin
          cur_d   = IW'(red_a_nxt);
          start_d = IW'(red_a_nxt);
        end
      end
      ufm_pkg::S_FIND_RD: begin
        p_raddr = cur_q;
      end
      ufm_pkg::S_FIND: begin
        if (p_rdata == cur_q) begin
          // Root found; restart at the start node for the compression pass.
          top_d   = cur_q;
          cur_d   = start_q;
          p_raddr = start_q;
        end else begin
          cur_d   = p_rdata;
          p_raddr = p_rdata;
        end
      end
      ufm_pkg::S_COMP: begin
        p_we    = 1'b1;
        p_waddr = cur_q;
        p_wdata = top_q;
        cur_d   = p_rdata;
        p_raddr = p_rdata;
      end
      ufm_pkg::S_SIZE_A: begin
        s_raddr = root_a_q;
      end
      ufm_pkg::S_SIZE_B: begin
        size_a_d = s_rdata;
        s_raddr  = root_b_q;
      end
      ufm_pkg::S_MERGE: begin
        res_joined_d = joined;
        if (joined) begin
          res_gain_d = '0;
          res_root_d = root_a_q;
          res_size_d = size_a_q;
        end else begin
          p_we       = 1'b1;
          p_waddr    = give_idx;
          p_wdata    = keep_idx;
          s_we       = 1'b1;
          s_waddr    = keep_idx;
          s_wdata    = size_sum;
          res_gain_d = ufm_pkg::GAIN_W'(size_prod);
          res_root_d = keep_idx;
          res_size_d = size_sum;
        end
      end
      ufm_pkg::S_DONE: begin
        s_raddr = root_a_q;
      end
      default: begin
        p_we = 1'b0;
      end
    endcase

    if (root_hit) begin
      if (!side_q) begin
        root_a_d = found_top;
        side_d   = 1'b1;
        cur_d    = IW'(idx_b_q);
        start_d  = IW'(idx_b_q);
      end else begin
        root_b_d = found_top;
      end
    end
  end

  always_comb begin
    out_valid_d  = out_valid_q && !out_take;
    out_joined_d = out_joined_q;
    out_gain_d   = out_gain_q;
    out_root_d   = out_root_q;
    out_size_d   = out_size_q;
    if (out_load) begin
      out_valid_d  = 1'b1;
      out_joined_d = res_joined_q;
      out_gain_d   = res_gain_q;
      out_root_d   = NW'(res_root_q);
      out_size_d   = ufm_pkg::MSIZE_W'(res_size_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ufm_pkg::S_CLEAR;
      clr_q       <= '0;
      side_q      <= 1'b0;
      red_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      side_q      <= side_d;
      red_cnt_q   <= red_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_a_q      <= idx_a_d;
    idx_b_q      <= idx_b_d;
    cur_q        <= cur_d;
    start_q      <= start_d;
    top_q        <= top_d;
    root_a_q     <= root_a_d;
    root_b_q     <= root_b_d;
    size_a_q     <= size_a_d;
    res_joined_q <= res_joined_d;
    res_gain_q   <= res_gain_d;
    res_root_q   <= res_root_d;
    res_size_q   <= res_size_d;
    out_joined_q <= out_joined_d;
    out_gain_q   <= out_gain_d;
    out_root_q   <= out_root_d;
    out_size_q   <= out_size_d;
  end

  `UFM_ASSERT(a_accept_leaves_idle, in_take |=> (state_q != ufm_pkg::S_IDLE), "pair accepted but sequencer stayed idle")
  `UFM_ASSERT(a_merge_distinct, ((state_q == ufm_pkg::S_MERGE) && p_we) |-> (p_waddr != p_wdata), "merge links a root to itself")
  `UFM_ASSERT(a_size_grows, ((state_q == ufm_pkg::S_MERGE) && s_we) |-> (s_wdata > size_a_q), "merged size did not grow")
  `UFM_ASSERT(a_done_loads_out, ((state_q == ufm_pkg::S_DONE) && (state_d == ufm_pkg::S_IDLE)) |=> out_valid_q, "finished pair left no result")

endmodule
